@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of the disjoint-set block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, off while reset is asserted
`define UFS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define UFS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/ufs_pkg.sv @@
// Package for the disjoint-set block: field widths, payload structs and the
// command/status structs between controller and datapath. No dependencies.
package ufs_pkg;

  localparam int ELEM_W       = 10;
  localparam int SZ_W         = 11;
  localparam int ELEMENTS_DEF = 1024;

  localparam logic OP_FIND  = 1'b0;
  localparam logic OP_UNITE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [ELEM_W-1:0] first_element;
    logic [ELEM_W-1:0] second_element;
  } ufs_in_t;

  typedef struct packed {
    logic [ELEM_W-1:0] root;
    logic              already_joined;
  } ufs_out_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic wrap;
    logic sel_b;
    logic walk_start;
    logic walk_step;
    logic comp_start;
    logic comp_step;
    logic merge;
    logic load_out;
  } ufs_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_unite;
    logic at_root;
    logic comp_skip;
    logic comp_last;
  } ufs_sts_t;

endpackage

@@ rtl/core/union_find_sets.sv @@
// Top level of the disjoint-set store; instantiates ufs_ctrl and ufs_dpath.
// Depends on ufs_pkg.
//
// One item is worked at a time. After reset a clearing pass sets every entry
// to its own parent with size one; in_stall is high for all of it. A find wraps
// the element index, walks to the root and compresses the path; a unite does
// this for both elements and then merges the two roots, and the next item is
// taken once the result is registered. The single read port of the parent
// memory yields one parent a cycle on both the root walk and the compression
// walk. Union by size keeps every depth at or below log2(ELEMENTS). A finished
// result waits in the output register, and the next item is taken while it waits.
module union_find_sets #(
  parameter int ELEMENTS = ufs_pkg::ELEMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ufs_pkg::ufs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ufs_pkg::ufs_out_t out_data
);
  import ufs_pkg::*;

  ufs_cmd_t cmd;
  ufs_sts_t sts;

  ufs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ufs_dpath #(
    .ELEMENTS (ELEMENTS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

@@ rtl/core/ufs_dpath.sv @@
// Datapath of the disjoint-set block: parent and size memories, index wrap,
// walk cursor, root and size registers, merge logic and output register.
// Depends on ufs_pkg.
module ufs_dpath #(
  parameter int ELEMENTS = ufs_pkg::ELEMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ufs_pkg::ufs_in_t   in_data,
  input  ufs_pkg::ufs_cmd_t  cmd,
  output ufs_pkg::ufs_sts_t  sts,
  output ufs_pkg::ufs_out_t  out_data
);
  import ufs_pkg::*;

  localparam int IDX_W   = $clog2(ELEMENTS);
  localparam int SHIFT   = ELEM_W + IDX_W;
  localparam int RECIP   = ((2 ** SHIFT) + ELEMENTS - 1) / ELEMENTS;
  localparam int RECIP_W = ELEM_W + 2;
  localparam int PROD_W  = ELEM_W + RECIP_W;
  localparam int REM_W   = ELEM_W + IDX_W + 1;

  logic [IDX_W-1:0]  parent_mem_r [ELEMENTS];
  logic [SZ_W-1:0]   size_mem_r   [ELEMENTS];

  logic              op_r;
  logic              joined_r;
  logic [ELEM_W-1:0] a_raw_r, b_raw_r, qa_r, qb_r;
  logic [IDX_W-1:0]  ea_r, eb_r, cur_r, root_a_r, root_b_r;
  logic [IDX_W-1:0]  clr_cnt_r, rd_parent_r;
  logic [SZ_W-1:0]   size_a_r, size_b_r, rd_size_r;
  ufs_out_t          out_data_r;

  logic [PROD_W-1:0] prod_a, prod_b;
  logic [REM_W-1:0]  rem_a, rem_b;
  logic [IDX_W-1:0]  start_idx, root_sel, rd_addr, win, lose;
  logic [SZ_W-1:0]   size_sum;
  logic              swap, same;

  logic              par_we, sz_we;
  logic [IDX_W-1:0]  par_waddr, par_wdata, sz_waddr;
  logic [SZ_W-1:0]   sz_wdata;

  assign prod_a = PROD_W'(in_data.first_element) * PROD_W'(RECIP);
  assign prod_b = PROD_W'(in_data.second_element) * PROD_W'(RECIP);
  assign rem_a  = REM_W'(a_raw_r) - REM_W'(qa_r) * REM_W'(ELEMENTS);
  assign rem_b  = REM_W'(b_raw_r) - REM_W'(qb_r) * REM_W'(ELEMENTS);

  assign start_idx = cmd.sel_b ? eb_r : ea_r;
  assign root_sel  = cmd.sel_b ? root_b_r : root_a_r;
  assign rd_addr   = (cmd.walk_start || cmd.comp_start) ? start_idx : rd_parent_r;

  assign swap     = size_a_r < size_b_r;
  assign same     = root_a_r == root_b_r;
  assign win      = swap ? root_b_r : root_a_r;
  assign lose     = swap ? root_a_r : root_b_r;
  assign size_sum = size_a_r + size_b_r;

  always_comb begin
    par_we    = 1'b0;
    par_waddr = clr_cnt_r;
    par_wdata = clr_cnt_r;
    sz_we     = 1'b0;
    sz_waddr  = clr_cnt_r;
    sz_wdata  = SZ_W'(1);
    if (cmd.clr_wr) begin
      par_we = 1'b1;
      sz_we  = 1'b1;
    end else if (cmd.comp_step) begin
      par_we    = 1'b1;
      par_waddr = cur_r;
      par_wdata = root_sel;
    end else if (cmd.merge && !same) begin
      par_we    = 1'b1;
      par_waddr = lose;
      par_wdata = win;
      sz_we     = 1'b1;
      sz_waddr  = win;
      sz_wdata  = size_sum;
    end
  end

  always_ff @(posedge clk) begin
    rd_parent_r <= parent_mem_r[rd_addr];
    rd_size_r   <= size_mem_r[rd_addr];
    if (par_we) begin
      parent_mem_r[par_waddr] <= par_wdata;
    end
    if (sz_we) begin
      size_mem_r[sz_waddr] <= sz_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_data.operation;
      a_raw_r  <= in_data.first_element;
      b_raw_r  <= in_data.second_element;
      qa_r     <= ELEM_W'(prod_a >> SHIFT);
      qb_r     <= ELEM_W'(prod_b >> SHIFT);
      joined_r <= 1'b0;
    end
    if (cmd.wrap) begin
      ea_r <= rem_a[IDX_W-1:0];
      eb_r <= rem_b[IDX_W-1:0];
    end
    if (cmd.walk_start || cmd.comp_start) begin
      cur_r <= start_idx;
    end
    if (cmd.walk_step) begin
      if (rd_parent_r == cur_r) begin
        if (cmd.sel_b) begin
          root_b_r <= cur_r;
          size_b_r <= rd_size_r;
        end else begin
          root_a_r <= cur_r;
          size_a_r <= rd_size_r;
        end
      end else begin
        cur_r <= rd_parent_r;
      end
    end
    if (cmd.comp_step) begin
      cur_r <= rd_parent_r;
    end
    if (cmd.merge) begin
      joined_r <= same;
      if (!same) begin
        root_a_r <= win;
      end
    end
    if (cmd.load_out) begin
      out_data_r.root           <= ELEM_W'(root_a_r);
      out_data_r.already_joined <= joined_r;
    end
  end

  assign sts.clr_last  = clr_cnt_r == IDX_W'(ELEMENTS - 1);
  assign sts.op_unite  = op_r == OP_UNITE;
  assign sts.at_root   = rd_parent_r == cur_r;
  assign sts.comp_skip = start_idx == root_sel;
  assign sts.comp_last = rd_parent_r == root_sel;

  assign out_data = out_data_r;

endmodule

@@ rtl/core/ufs_ctrl.sv @@
// Controller of the disjoint-set block: sequences clearing, index wrap, root
// walks, path compression and merge, and owns both handshakes. Uses ufs_pkg.
module ufs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ufs_pkg::ufs_sts_t sts,
  output ufs_pkg::ufs_cmd_t cmd
);
  import ufs_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_WALK_START,
    ST_WALK,
    ST_COMP_START,
    ST_COMP,
    ST_MERGE,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   sel_b_r, sel_b_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   elem_done, out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    sel_b_nxt = sel_b_r;
    elem_done = 1'b0;
    cmd       = '0;
    cmd.sel_b = sel_b_r;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_WRAP;
        end
      end
      ST_WRAP: begin
        cmd.wrap  = 1'b1;
        sel_b_nxt = 1'b0;
        state_nxt = ST_WALK_START;
      end
      ST_WALK_START: begin
        cmd.walk_start = 1'b1;
        state_nxt      = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.at_root) state_nxt = ST_COMP_START;
      end
      ST_COMP_START: begin
        cmd.comp_start = 1'b1;
        if (sts.comp_skip) elem_done = 1'b1;
        else state_nxt = ST_COMP;
      end
      ST_COMP: begin
        cmd.comp_step = 1'b1;
        if (sts.comp_last) elem_done = 1'b1;
      end
      ST_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
    if (elem_done) begin
      if (sel_b_r) begin
        state_nxt = ST_MERGE;
      end else if (sts.op_unite) begin
        sel_b_nxt = 1'b1;
        state_nxt = ST_WALK_START;
      end else begin
        state_nxt = ST_FINISH;
      end
    end
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && out_stall);
  assign in_stall_nxt  = state_nxt != ST_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sel_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
      in_stall_r  <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      sel_b_r     <= sel_b_nxt;
      out_valid_r <= out_valid_nxt;
      in_stall_r  <= in_stall_nxt;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/ufs_checker.sv @@
// Port-level checker for union_find_sets and the bind that attaches it.
// Depends on ufs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ufs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input ufs_pkg::ufs_out_t out_data
);

  `UFS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
  `UFS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data), "stalled result changed")
  `UFS_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall, "second item taken while busy")
  `UFS_ASSERT_NEXT_ALWAYS(a_stall_after_reset, clk, !rst_n, in_stall && !out_valid, "block open during clearing")

endmodule

bind union_find_sets ufs_checker u_ufs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for union_find_sets: drives find and unite requests,
// predicts each root and joined flag with its own union-by-size store.
// Depends on ufs_pkg and the union_find_sets RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ufs_pkg::*;

  localparam int NODES      = 1 << ELEM_W;
  localparam int RAND_ITEMS = 750;
  localparam int QUIET_TAIL = 150;
  localparam int LONG_HOLD  = 200;
  localparam int CYCLE_CAP  = 500000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ufs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ufs_out_t out_data;

  ufs_in_t  request_q[$];
  ufs_out_t answer_q[$];

  logic [ELEM_W-1:0] up_link[NODES];
  logic [SZ_W-1:0]   group_count[NODES];

  int  total_items = 0;
  int  accepted = 0;
  int  results_seen = 0;
  int  failures = 0;
  int  cycles = 0;
  bit  in_taken = 1'b0;
  bit  quiet = 1'b0;
  int  send_gap = 0;
  int  hold_left = 0;
  int  next_long_mark = 60;

  union_find_sets dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [ELEM_W-1:0] trace_root(input logic [ELEM_W-1:0] start);
    logic [ELEM_W-1:0] top;
    logic [ELEM_W-1:0] walk;
    logic [ELEM_W-1:0] nxt;
    top = start;
    while (up_link[top] != top) top = up_link[top];
    walk = start;
    while (walk != top) begin
      nxt = up_link[walk];
      up_link[walk] = top;
      walk = nxt;
    end
    return top;
  endfunction

  function automatic ufs_out_t resolve_request(input ufs_in_t req);
    ufs_out_t          res;
    logic [ELEM_W-1:0] ra;
    logic [ELEM_W-1:0] rb;
    logic [ELEM_W-1:0] swap;
    res = '0;
    ra = trace_root(req.first_element);
    if (req.operation == OP_UNITE) begin
      rb = trace_root(req.second_element);
      if (ra == rb) begin
        res.already_joined = 1'b1;
      end else begin
        if (group_count[ra] < group_count[rb]) begin
          swap = ra;
          ra = rb;
          rb = swap;
        end
        group_count[ra] = group_count[ra] + group_count[rb];
        up_link[rb] = ra;
      end
    end
    res.root = ra;
    return res;
  endfunction

  task automatic queue_request(input logic op, input int a, input int b);
    ufs_in_t req;
    req.operation = op;
    req.first_element = a[ELEM_W-1:0];
    req.second_element = b[ELEM_W-1:0];
    request_q.push_back(req);
  endtask

  // sender: change inputs on the falling edge, hold a stalled transfer
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 3);
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_data <= request_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: short random stalls plus a few long hold-offs
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!quiet && results_seen >= next_long_mark) begin
        next_long_mark += 250;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    ufs_out_t want;
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end else begin
      in_taken = rst_n && in_valid && !in_stall;
      if (in_taken) begin
        answer_q.push_back(resolve_request(in_data));
        accepted++;
        quiet = accepted >= total_items - QUIET_TAIL;
      end
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (answer_q.size() == 0) begin
          failures++;
          $display("%0t: unexpected result root=%0d joined=%0b", $realtime,
                   out_data.root, out_data.already_joined);
        end else begin
          want = answer_q.pop_front();
          if (out_data.root !== want.root) begin
            failures++;
            $display("%0t: root expected %0d actual %0d", $realtime, want.root,
                     out_data.root);
          end
          if (out_data.already_joined !== want.already_joined) begin
            failures++;
            $display("%0t: already_joined expected %0b actual %0b", $realtime,
                     want.already_joined, out_data.already_joined);
          end
        end
      end
    end
  end

  initial begin
    int base;
    int a;
    int b;
    logic op;
    for (int i = 0; i < NODES; i++) begin
      up_link[i] = i[ELEM_W-1:0];
      group_count[i] = SZ_W'(1);
    end

    queue_request(OP_FIND, 0, 0);
    queue_request(OP_FIND, 1023, 1023);
    queue_request(OP_UNITE, 0, 1023);
    queue_request(OP_UNITE, 1023, 0);
    queue_request(OP_UNITE, 5, 5);
    queue_request(OP_FIND, 1023, 682);
    queue_request(OP_UNITE, 1, 2);
    queue_request(OP_UNITE, 3, 4);
    queue_request(OP_UNITE, 1, 3);
    queue_request(OP_UNITE, 6, 1);
    queue_request(OP_FIND, 2, 341);
    queue_request(OP_FIND, 4, 0);
    queue_request(OP_UNITE, 1023, 1);
    queue_request(OP_UNITE, 2, 0);
    queue_request(OP_UNITE, 341, 682);
    queue_request(OP_UNITE, 682, 341);
    queue_request(OP_UNITE, 7, 8);
    queue_request(OP_UNITE, 9, 10);
    queue_request(OP_UNITE, 7, 9);
    queue_request(OP_UNITE, 11, 4);
    queue_request(OP_FIND, 10, 1023);
    queue_request(OP_UNITE, 10, 6);
    queue_request(OP_FIND, 8, 0);

    // clustered elements build deep trees; the rest spread over the full range
    base = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) base = $urandom_range(0, NODES - 32);
      op = ($urandom_range(0, 9) < 6) ? OP_UNITE : OP_FIND;
      a = ($urandom_range(0, 9) < 7) ? base + $urandom_range(0, 31)
                                     : $urandom_range(0, NODES - 1);
      b = ($urandom_range(0, 9) < 7) ? base + $urandom_range(0, 31)
                                     : $urandom_range(0, NODES - 1);
      queue_request(op, a, b);
    end
    total_items = request_q.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() > 0 || in_valid || answer_q.size() > 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
